// ===== sv/msr_pkg.sv =====
`timescale 1ns / 1ps

package msr_pkg;

   // Default geometry and the fixed field width of the stream data
   localparam int MATRIX_SIZE_DEF   = 8;
   localparam int ELEMENT_WIDTH_DEF = 32;
   localparam int DATA_WIDTH        = 32;
   localparam int MODE_WIDTH        = 2;

   // Output order selected by the mode register
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_SPIRAL    = 2'd0,
      MODE_ROTATE    = 2'd1,
      MODE_TRANSPOSE = 2'd2,
      MODE_ROW_MAJOR = 2'd3
   } mode_type;

   // Walk direction of the spiral address generator
   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   // One matrix ready to emit: which buffer bank and which order
   typedef struct packed {
      logic     bank;
      mode_type mode;
   } job_type;

endpackage

// ===== sv/msr_ram.sv =====
`timescale 1ns / 1ps

module msr_ram #(
   parameter int Width = 32,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/msr_front.sv =====
`timescale 1ns / 1ps

module msr_front #(
   parameter int MatrixSize   = msr_pkg::MATRIX_SIZE_DEF,
   parameter int ElementWidth = msr_pkg::ELEMENT_WIDTH_DEF,
   localparam int CellCount   = MatrixSize * MatrixSize,
   localparam int IdxWidth    = (CellCount > 1) ? $clog2(CellCount) : 1,
   localparam int StoreWidth  = (ElementWidth < msr_pkg::DATA_WIDTH) ?
                                ElementWidth : msr_pkg::DATA_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               space_ok,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [msr_pkg::DATA_WIDTH-1:0]     req_tdata,
   input  logic                               csr_wr_en,
   input  logic [msr_pkg::MODE_WIDTH-1:0]     csr_wr_data,
   output logic                               ram_wr_en,
   output logic [IdxWidth:0]                  ram_wr_addr,
   output logic [StoreWidth-1:0]              ram_wr_data,
   output logic                               job_push,
   output msr_pkg::job_type                   job_out
);

   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(CellCount - 1);

   logic [IdxWidth-1:0] load_count_ff, load_count_in;
   logic                bank_ff, bank_in;
   msr_pkg::mode_type   mode_ff, mode_in;
   logic                accept;
   logic                last_elem;

   assign req_tready = space_ok;
   assign accept     = req_tvalid && space_ok;
   assign last_elem  = (load_count_ff == LastIdx);

   assign ram_wr_en   = accept;
   assign ram_wr_addr = {bank_ff, load_count_ff};
   assign ram_wr_data = req_tdata[StoreWidth-1:0];

   // mode is sampled when the last element of the matrix lands
   assign job_push     = accept && last_elem;
   assign job_out.bank = bank_ff;
   assign job_out.mode = mode_ff;

   always_comb begin
      load_count_in = load_count_ff;
      bank_in       = bank_ff;
      mode_in       = mode_ff;
      if (csr_wr_en) begin
         mode_in = msr_pkg::mode_type'(csr_wr_data);
      end
      if (accept) begin
         if (last_elem) begin
            load_count_in = '0;
            bank_in       = ~bank_ff;
         end else begin
            load_count_in = load_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         bank_ff       <= 1'b0;
         mode_ff       <= msr_pkg::MODE_SPIRAL;
      end else begin
         load_count_ff <= load_count_in;
         bank_ff       <= bank_in;
         mode_ff       <= mode_in;
      end
   end

endmodule

// ===== sv/msr_queue.sv =====
`timescale 1ns / 1ps

module msr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  msr_pkg::job_type push_job,
   input  logic             pop,
   output logic             head_valid,
   output msr_pkg::job_type head_job,
   output logic [1:0]       count
);

   msr_pkg::job_type entries_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== sv/msr_back.sv =====
`timescale 1ns / 1ps

module msr_back #(
   parameter int MatrixSize   = msr_pkg::MATRIX_SIZE_DEF,
   parameter int ElementWidth = msr_pkg::ELEMENT_WIDTH_DEF,
   localparam int CellCount   = MatrixSize * MatrixSize,
   localparam int IdxWidth    = (CellCount > 1) ? $clog2(CellCount) : 1,
   localparam int StoreWidth  = (ElementWidth < msr_pkg::DATA_WIDTH) ?
                                ElementWidth : msr_pkg::DATA_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  msr_pkg::job_type               job_in,
   output logic                           job_pop,
   output logic                           busy,
   output logic                           ram_rd_en,
   output logic [IdxWidth:0]              ram_rd_addr,
   input  logic [StoreWidth-1:0]          ram_rd_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [msr_pkg::DATA_WIDTH-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int CoordWidth = (MatrixSize > 1) ? $clog2(MatrixSize) : 1;
   localparam logic [IdxWidth-1:0]   LastIdx   = IdxWidth'(CellCount - 1);
   localparam logic [IdxWidth-1:0]   SizeIdx   = IdxWidth'(MatrixSize);
   localparam logic [CoordWidth-1:0] LastCoord = CoordWidth'(MatrixSize - 1);

   // walker state
   logic                  busy_ff, busy_in;
   msr_pkg::job_type      job_ff, job_in_nxt;
   logic [CoordWidth-1:0] row_ff, row_in;
   logic [CoordWidth-1:0] col_ff, col_in;
   logic [CoordWidth-1:0] ring_ff, ring_in;
   msr_pkg::dir_type      dir_ff, dir_in;
   logic [IdxWidth-1:0]   count_ff, count_in;

   // read pipeline: stage 1 is the RAM output register, stage 2 the output register
   logic                  s1_valid_ff, s1_last_ff;
   logic                  s2_valid_ff, s2_last_ff;
   logic [StoreWidth-1:0] s2_data_ff;

   logic                  advance;
   logic                  issue;
   logic                  last_read;
   logic [CoordWidth-1:0] ring_hi;
   logic [CoordWidth-1:0] rd_row;
   logic [CoordWidth-1:0] rd_col;

   assign advance   = !s2_valid_ff || rsp_tready;
   assign issue     = busy_ff && advance;
   assign last_read = (count_ff == LastIdx);
   assign ring_hi   = LastCoord - ring_ff;

   assign busy      = busy_ff;
   assign job_pop   = !busy_ff && job_valid;
   assign ram_rd_en = advance;

   // map the walk position to a stored (row, col)
   always_comb begin
      unique case (job_ff.mode)
         msr_pkg::MODE_ROTATE: begin
            rd_row = LastCoord - col_ff;
            rd_col = row_ff;
         end
         msr_pkg::MODE_TRANSPOSE: begin
            rd_row = col_ff;
            rd_col = row_ff;
         end
         default: begin
            rd_row = row_ff;
            rd_col = col_ff;
         end
      endcase
   end

   assign ram_rd_addr = {job_ff.bank,
                         IdxWidth'(IdxWidth'(rd_row) * SizeIdx + IdxWidth'(rd_col))};

   always_comb begin
      busy_in    = busy_ff;
      job_in_nxt = job_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      ring_in    = ring_ff;
      dir_in     = dir_ff;
      count_in   = count_ff;
      if (job_pop) begin
         busy_in    = 1'b1;
         job_in_nxt = job_in;
         row_in     = '0;
         col_in     = '0;
         ring_in    = '0;
         dir_in     = msr_pkg::DIR_RIGHT;
         count_in   = '0;
      end else if (issue) begin
         count_in = count_ff + 1'b1;
         if (last_read) begin
            busy_in = 1'b0;
         end
         if (job_ff.mode == msr_pkg::MODE_SPIRAL) begin
            // clockwise ring walk; the count ends the run at the center
            unique case (dir_ff)
               msr_pkg::DIR_RIGHT: begin
                  if (col_ff < ring_hi) begin
                     col_in = col_ff + 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                     dir_in = msr_pkg::DIR_DOWN;
                  end
               end
               msr_pkg::DIR_DOWN: begin
                  if (row_ff < ring_hi) begin
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff - 1'b1;
                     dir_in = msr_pkg::DIR_LEFT;
                  end
               end
               msr_pkg::DIR_LEFT: begin
                  if (col_ff > ring_ff) begin
                     col_in = col_ff - 1'b1;
                  end else begin
                     row_in = row_ff - 1'b1;
                     dir_in = msr_pkg::DIR_UP;
                  end
               end
               msr_pkg::DIR_UP: begin
                  if (row_ff > ring_ff + 1'b1) begin
                     row_in = row_ff - 1'b1;
                  end else begin
                     // step into the next ring at its top-left corner
                     col_in  = col_ff + 1'b1;
                     ring_in = ring_ff + 1'b1;
                     dir_in  = msr_pkg::DIR_RIGHT;
                  end
               end
            endcase
         end else begin
            // plain raster over the result matrix
            if (col_ff == LastCoord) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in_nxt;
      row_ff  <= row_in;
      col_ff  <= col_in;
      ring_ff <= ring_in;
      dir_ff  <= dir_in;
      if (advance) begin
         s2_data_ff <= ram_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_last_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         if (advance) begin
            s1_valid_ff <= issue;
            s1_last_ff  <= issue && last_read;
            s2_valid_ff <= s1_valid_ff;
            s2_last_ff  <= s1_last_ff;
         end
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = msr_pkg::DATA_WIDTH'(s2_data_ff);
   assign rsp_tlast  = s2_last_ff;

endmodule

// ===== sv/matrix_spiral_rotate_reorder_top.sv =====
`timescale 1ns / 1ps
// Output: after its last element is accepted, a matrix goes through the job queue, the walker
//   and the RAM and output registers; its MatrixSize*MatrixSize results then follow at one per
//   cycle while rsp_tready is high (one RAM read port). Input: one element per cycle while a
//   buffer bank is free; two banks let the next matrix load while the previous one drains.
// Reset: synchronous, active high; clears counters, queue, pipeline valids, mode to spiral.
//   Element buffer contents are not cleared.
module matrix_spiral_rotate_reorder_top #(
   parameter int MatrixSize   = msr_pkg::MATRIX_SIZE_DEF,
   parameter int ElementWidth = msr_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // element input
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [msr_pkg::DATA_WIDTH-1:0] req_tdata,   // [31:0] element_value
   // reordered output
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [msr_pkg::DATA_WIDTH-1:0] rsp_tdata,   // [31:0] out_value
   output logic                           rsp_tlast,   // is_last
   // order mode register
   input  logic                           csr_wr_en,
   input  logic [msr_pkg::MODE_WIDTH-1:0] csr_wr_data  // order_mode
);

   localparam int CellCount  = MatrixSize * MatrixSize;
   localparam int IdxWidth   = (CellCount > 1) ? $clog2(CellCount) : 1;
   localparam int StoreWidth = (ElementWidth < msr_pkg::DATA_WIDTH) ?
                               ElementWidth : msr_pkg::DATA_WIDTH;
   // two banks, each one full matrix; address is {bank, row*N + col}
   localparam int RamDepth   = 2 * (2 ** IdxWidth);

   logic                  space_ok;
   logic                  ram_wr_en;
   logic [IdxWidth:0]     ram_wr_addr;
   logic [StoreWidth-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [IdxWidth:0]     ram_rd_addr;
   logic [StoreWidth-1:0] ram_rd_data;
   logic                  job_push;
   msr_pkg::job_type      push_job;
   logic                  job_pop;
   logic                  head_valid;
   msr_pkg::job_type      head_job;
   logic [1:0]            queue_count;
   logic                  back_busy;
   logic [2:0]            banks_held;

   // a bank stays held from its last element until the back end issued its last read;
   // the front loads only while the bank it points at is not held
   assign banks_held = {1'b0, queue_count} + {2'b0, back_busy};
   assign space_ok   = (banks_held < 3'd2);

   msr_front #(
      .MatrixSize   (MatrixSize),
      .ElementWidth (ElementWidth)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .space_ok    (space_ok),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .job_push    (job_push),
      .job_out     (push_job)
   );

   msr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .count      (queue_count)
   );

   msr_ram #(
      .Width (StoreWidth),
      .Depth (RamDepth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   msr_back #(
      .MatrixSize   (MatrixSize),
      .ElementWidth (ElementWidth)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job_in      (head_job),
      .job_pop     (job_pop),
      .busy        (back_busy),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int N          = msr_pkg::MATRIX_SIZE_DEF;
   localparam int CELLS      = N * N;
   localparam int SETTLE     = 8;     // margin for the output pipeline to empty
   localparam int QUIET_MAX  = 2000;  // cycles without any item moving
   localparam int RAND_ITEMS = 90;

   typedef enum int {
      FILL_RAMP, FILL_CONST, FILL_ALT, FILL_RANDOM, FILL_SMALL, FILL_EDGE
   } fill_kind_type;
   typedef enum int {EXP_MODEL, EXP_CONST, EXP_INDEX} exp_kind_type;

   typedef struct {
      bit                write_mode;
      msr_pkg::mode_type mode;
      msr_pkg::mode_type late_mode;
      int                late_at;     // 0: no mid-load mode change
      fill_kind_type     fill;
      logic [31:0]       fill_value;
      exp_kind_type      check;
   } plan_row_type;

   typedef struct {
      logic [31:0] value;
      logic        last;
   } reordered_item_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [msr_pkg::DATA_WIDTH-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [msr_pkg::DATA_WIDTH-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_wr_en = 1'b0;
   msr_pkg::mode_type              csr_wr_data = msr_pkg::MODE_SPIRAL;

   // Predictor state
   logic [31:0]        cell_store [CELLS];
   int                 fill_count = 0;
   msr_pkg::mode_type  order_mode = msr_pkg::MODE_SPIRAL;
   reordered_item_type pending_out [$];

   // Where the directed rows take their expected values from
   exp_kind_type exp_source = EXP_MODEL;
   logic [31:0]  exp_const  = '0;

   int  mismatches     = 0;
   int  results_seen   = 0;
   int  elements_sent  = 0;
   int  runs_by_mode [4] = '{0, 0, 0, 0};
   int  quiet_cycles   = 0;
   bit  send_calm      = 1'b0;
   bit  recv_calm      = 1'b0;

   plan_row_type directed_plan [5] = '{
      // after reset: spiral is the default order, no register write
      '{1'b0, msr_pkg::MODE_SPIRAL, msr_pkg::MODE_SPIRAL, 0, FILL_RAMP, 32'h0,
        EXP_MODEL},
      // row-major of a ramp reads back the load index
      '{1'b1, msr_pkg::MODE_ROW_MAJOR, msr_pkg::MODE_ROW_MAJOR, 0, FILL_RAMP, 32'h0,
        EXP_INDEX},
      '{1'b1, msr_pkg::MODE_ROTATE, msr_pkg::MODE_ROTATE, 0, FILL_RAMP, 32'h0,
        EXP_MODEL},
      // mode changed while loading: only the mode at the last element counts
      '{1'b1, msr_pkg::MODE_SPIRAL, msr_pkg::MODE_TRANSPOSE, 30, FILL_RANDOM, 32'h0,
        EXP_MODEL},
      '{1'b1, msr_pkg::MODE_ROTATE, msr_pkg::MODE_ROW_MAJOR, 63, FILL_CONST,
        32'hFFFF_FFFF, EXP_CONST}
   };

   matrix_spiral_rotate_reorder_top #(
      .MatrixSize  (N),
      .ElementWidth(msr_pkg::ELEMENT_WIDTH_DEF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stores one element; on the last element of a matrix, queues the reordered run.
   function automatic void absorb_element(input logic [31:0] v);
      int                 src [$];
      int                 top, bot, lft, rgt, r, c, k;
      reordered_item_type item;
      cell_store[fill_count] = v;
      fill_count++;
      if (fill_count < CELLS) return;
      fill_count = 0;
      runs_by_mode[order_mode]++;
      case (order_mode)
         msr_pkg::MODE_SPIRAL: begin
            top = 0; bot = N - 1; lft = 0; rgt = N - 1;
            while (top <= bot && lft <= rgt) begin
               for (c = lft; c <= rgt; c++) src.push_back(top * N + c);
               for (r = top + 1; r <= bot; r++) src.push_back(r * N + rgt);
               if (top < bot)
                  for (c = rgt - 1; c >= lft; c--) src.push_back(bot * N + c);
               if (lft < rgt)
                  for (r = bot - 1; r > top; r--) src.push_back(r * N + lft);
               top++; bot--; lft++; rgt--;
            end
         end
         msr_pkg::MODE_ROTATE: begin
            // result (r,c) comes from stored (N-1-c, r)
            for (r = 0; r < N; r++)
               for (c = 0; c < N; c++) src.push_back((N - 1 - c) * N + r);
         end
         msr_pkg::MODE_TRANSPOSE: begin
            for (r = 0; r < N; r++)
               for (c = 0; c < N; c++) src.push_back(c * N + r);
         end
         default: begin
            for (r = 0; r < N; r++)
               for (c = 0; c < N; c++) src.push_back(r * N + c);
         end
      endcase
      for (k = 0; k < CELLS; k++) begin
         case (exp_source)
            EXP_CONST: item.value = exp_const;
            EXP_INDEX: item.value = k;
            default:   item.value = cell_store[src[k]];
         endcase
         item.last = (k == CELLS - 1);
         pending_out.push_back(item);
      end
   endfunction

   function automatic logic [31:0] element_for(input fill_kind_type kind,
                                               input logic [31:0] base, input int idx);
      logic [31:0] edges [5];
      edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      case (kind)
         FILL_RAMP:   return idx;
         FILL_CONST:  return base;
         FILL_ALT:    return idx[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
         FILL_SMALL:  return $signed($urandom_range(0, 15)) - 8;
         FILL_EDGE:   return edges[$urandom_range(0, 4)];
         default:     return $urandom;
      endcase
   endfunction

   task automatic send_element(input logic [31:0] v);
      int gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      absorb_element(v);
      elements_sent++;
   endtask

   // Hold the sender until the block has drained, then give it time to go idle.
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_order_mode(input msr_pkg::mode_type m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      order_mode = m;
   endtask

   // Result side: random backpressure, each accepted item checked against the queue head.
   initial begin
      int                 gap;
      reordered_item_type want;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
         gap = recv_calm ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         if (pending_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected result: data=%h last=%b", $realtime, rsp_tdata,
                        rsp_tlast);
         end else begin
            want = pending_out.pop_front();
            if (rsp_tdata !== want.value || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] result %0d: expected data=%h last=%b, got data=%h last=%b",
                           $realtime, results_seen, want.value, want.last, rsp_tdata,
                           rsp_tlast);
            end
         end
      end
   end

   // Watchdog: ends the run if no item moves on either stream for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("Watchdog expired after %0d idle cycles", QUIET_MAX);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      plan_row_type  row;
      fill_kind_type style;
      int            late_at;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed matrices: every order, extreme values, mid-load mode changes
      foreach (directed_plan[r]) begin
         row = directed_plan[r];
         if (row.write_mode) begin
            drain_outputs();
            write_order_mode(row.mode);
         end
         exp_source = row.check;
         exp_const  = row.fill_value;
         for (int e = 0; e < CELLS; e++) begin
            if (row.late_at != 0 && e == row.late_at) begin
               drain_outputs();
               write_order_mode(row.late_mode);
            end
            send_element(element_for(row.fill, row.fill_value, e));
         end
      end
      exp_source = EXP_MODEL;

      // Random matrices; the tail leaves a partly loaded matrix behind
      style   = FILL_RANDOM;
      late_at = 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (fill_count == 0) begin
            case ($urandom_range(0, 3))
               0:       style = FILL_SMALL;
               1:       style = FILL_EDGE;
               default: style = FILL_RANDOM;
            endcase
            if ($urandom_range(0, 1) == 1) begin
               drain_outputs();
               write_order_mode(msr_pkg::mode_type'($urandom_range(0, 3)));
            end
            late_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, CELLS - 1) : 0;
         end
         if (late_at != 0 && fill_count == late_at) begin
            drain_outputs();
            write_order_mode(msr_pkg::mode_type'($urandom_range(0, 3)));
         end
         send_element(element_for(style, 32'h0, fill_count));
      end

      drain_outputs();
      $display("Sent %0d elements, checked %0d reordered results", elements_sent,
               results_seen);
      $display("Matrices per order: spiral %0d, rotate %0d, transpose %0d, row-major %0d",
               runs_by_mode[msr_pkg::MODE_SPIRAL], runs_by_mode[msr_pkg::MODE_ROTATE],
               runs_by_mode[msr_pkg::MODE_TRANSPOSE], runs_by_mode[msr_pkg::MODE_ROW_MAJOR]);
      if (mismatches == 0 && pending_out.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
